// File: design/utf8_stream_validator_defines.svh
// Assertion macros shared by the validator RTL
`ifndef UTF8_STREAM_VALIDATOR_DEFINES_SVH
`define UTF8_STREAM_VALIDATOR_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define UTFV_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define UTFV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/utfv_pkg.sv
// Types and constants of the UTF-8 stream validator
package utfv_pkg;

    localparam int unsigned CODE_W = 21;

    localparam logic [CODE_W-1:0] C_MIN_2BYTE  = 21'h00_0080;
    localparam logic [CODE_W-1:0] C_MIN_3BYTE  = 21'h00_0800;
    localparam logic [CODE_W-1:0] C_MIN_4BYTE  = 21'h01_0000;
    localparam logic [CODE_W-1:0] C_MAX_CODE   = 21'h10_FFFF;
    localparam logic [CODE_W-1:0] C_SURR_LO    = 21'h00_D800;
    localparam logic [CODE_W-1:0] C_SURR_HI    = 21'h00_DFFF;

    localparam logic [7:0] C_ASCII_LIMIT = 8'h80;
    localparam logic [7:0] C_LEAD2_MASK  = 8'hE0;
    localparam logic [7:0] C_LEAD2_VAL   = 8'hC0;
    localparam logic [7:0] C_LEAD3_MASK  = 8'hF0;
    localparam logic [7:0] C_LEAD3_VAL   = 8'hE0;
    localparam logic [7:0] C_LEAD4_MASK  = 8'hF8;
    localparam logic [7:0] C_LEAD4_VAL   = 8'hF0;
    localparam logic [7:0] C_CONT_MASK   = 8'hC0;
    localparam logic [7:0] C_CONT_VAL    = 8'h80;
    localparam logic [7:0] C_CONT_BITS   = 8'h3F;
    localparam logic [7:0] C_LEAD2_BITS  = 8'h1F;
    localparam logic [7:0] C_LEAD3_BITS  = 8'h0F;
    localparam logic [7:0] C_LEAD4_BITS  = 8'h07;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_string;
    } t_in_item;

    typedef struct packed {
        logic [1:0]        bytes_pending;
        logic [1:0]        sequence_length;
        logic [CODE_W-1:0] partial_code;
        logic              error_seen;
    } t_state;

endpackage

// File: design/utfv_stream_if.sv
// Valid/ready channel interfaces for the validator input and result streams
interface utfv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_string;

    modport source (output valid, output data_byte, output has_byte,
                    output end_of_string, input ready);
    modport sink   (input valid, input data_byte, input has_byte,
                    input end_of_string, output ready);
endinterface

interface utfv_out_if;
    logic valid;
    logic ready;
    logic is_valid;

    modport source (output valid, output is_valid, input ready);
    modport sink   (input valid, input is_valid, output ready);
endinterface

// File: design/utfv_step.sv
// Per-byte decode step: next running state and verdict for one item
module utfv_step (
    input  utfv_pkg::t_state   i_state,
    input  utfv_pkg::t_in_item i_item,
    output utfv_pkg::t_state   o_state,
    output logic               o_is_valid
);
    import utfv_pkg::*;

    t_state            n_state;
    logic [CODE_W-1:0] code;
    logic [7:0]        c;
    logic              bad_code;

    always_comb begin
        c        = i_item.data_byte;
        n_state  = i_state;
        code     = {i_state.partial_code[CODE_W-7:0], c[5:0]};
        bad_code = ((i_state.sequence_length == 2'd1) && (code < C_MIN_2BYTE)) ||
                   ((i_state.sequence_length == 2'd2) && (code < C_MIN_3BYTE)) ||
                   ((i_state.sequence_length == 2'd3) && (code < C_MIN_4BYTE)) ||
                   (code > C_MAX_CODE) ||
                   ((code >= C_SURR_LO) && (code <= C_SURR_HI));

        if (i_item.has_byte && !i_state.error_seen) begin
            if (i_state.bytes_pending == 2'd0) begin
                if (c == 8'h00) begin
                    n_state.error_seen = 1'b1;
                end else if (c < C_ASCII_LIMIT) begin
                    n_state = i_state;
                end else if ((c & C_LEAD2_MASK) == C_LEAD2_VAL) begin
                    n_state.bytes_pending   = 2'd1;
                    n_state.sequence_length = 2'd1;
                    n_state.partial_code    = CODE_W'(c & C_LEAD2_BITS);
                end else if ((c & C_LEAD3_MASK) == C_LEAD3_VAL) begin
                    n_state.bytes_pending   = 2'd2;
                    n_state.sequence_length = 2'd2;
                    n_state.partial_code    = CODE_W'(c & C_LEAD3_BITS);
                end else if ((c & C_LEAD4_MASK) == C_LEAD4_VAL) begin
                    n_state.bytes_pending   = 2'd3;
                    n_state.sequence_length = 2'd3;
                    n_state.partial_code    = CODE_W'(c & C_LEAD4_BITS);
                end else begin
                    n_state.error_seen = 1'b1;
                end
            end else if ((c & C_CONT_MASK) != C_CONT_VAL) begin
                n_state.error_seen = 1'b1;
            end else begin
                n_state.partial_code  = code;
                n_state.bytes_pending = i_state.bytes_pending - 2'd1;
                if (n_state.bytes_pending == 2'd0) begin
                    // sequence complete: range, overlong and surrogate checks
                    if (bad_code) begin
                        n_state.error_seen = 1'b1;
                    end
                    n_state.sequence_length = 2'd0;
                    n_state.partial_code    = '0;
                end
            end
        end

        o_is_valid = !n_state.error_seen && (n_state.bytes_pending == 2'd0);
        o_state    = i_item.end_of_string ? t_state'('0) : n_state;
    end

endmodule

// File: design/utf8_stream_validator.sv
// UTF-8 stream validator top level
//
//  channel   dir  payload                                 transfer
//  i_in      in   data_byte[7:0], has_byte, end_of_string  valid && ready
//  o_out     out  is_valid                                 valid && ready
//
// One byte per cycle unless a closing item waits on a held verdict; a verdict leaves
// through the input register, then the result register. The decode step is shallow
// logic on the running state held between the two registers.
// Reset is synchronous, active low, and clears all control and running state.
// A verdict waiting on o_out stalls a closing item and all items behind it; others flow.
`include "utf8_stream_validator_defines.svh"

module utf8_stream_validator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    utfv_in_if.sink     i_in,
    utfv_out_if.source  o_out
);
    import utfv_pkg::*;

    logic     r_in_valid;
    t_in_item r_in;
    t_state   r_state;
    logic     r_out_valid;
    logic     r_out_is_valid;

    t_state   n_state;
    logic     n_is_valid;
    logic     advance;
    logic     out_free;

    utfv_step u_step (
        .i_state    (r_state),
        .i_item     (r_in),
        .o_state    (n_state),
        .o_is_valid (n_is_valid)
    );

    assign out_free    = !r_out_valid || o_out.ready;
    assign advance     = r_in_valid && (!r_in.end_of_string || out_free);
    assign i_in.ready  = !r_in_valid || advance;
    assign o_out.valid = r_out_valid;
    assign o_out.is_valid = r_out_is_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end

            if (advance) begin
                r_state <= n_state;
            end

            if (advance && r_in.end_of_string) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in.data_byte     <= i_in.data_byte;
            r_in.has_byte      <= i_in.has_byte;
            r_in.end_of_string <= i_in.end_of_string;
        end
        if (advance && r_in.end_of_string) begin
            r_out_is_valid <= n_is_valid;
        end
    end

    `UTFV_ASSERT_NEXT(a_verdict_loaded, i_clk, i_rst_n,
        advance && r_in.end_of_string, r_out_valid && r_state == t_state'('0),
        "closing item did not load a verdict and clear state")

    `UTFV_ASSERT_NEXT(a_held_item_kept, i_clk, i_rst_n,
        r_in_valid && !advance, r_in_valid && $stable(r_in),
        "stalled input register lost its item")

    `UTFV_ASSERT_NOW(a_pending_le_len, i_clk, i_rst_n,
        r_state.bytes_pending != 2'd0,
        r_state.sequence_length >= r_state.bytes_pending,
        "more continuation bytes pending than the sequence holds")

    `UTFV_ASSERT_NEXT(a_state_held, i_clk, i_rst_n,
        !advance, $stable(r_state),
        "running state changed without an item")

endmodule

// File: sim/utf8_stream_validator_test.sv
// Self-checking testbench for the UTF-8 stream validator: byte strings in, one verdict out
module utf8_stream_validator_test;
    timeunit 1ns;
    timeprecision 1ps;

    import utfv_pkg::*;

    typedef enum int {
        FLAW_NUL,
        FLAW_ANY_BYTE,
        FLAW_OVERLONG,
        FLAW_SURROGATE,
        FLAW_TOO_HIGH,
        FLAW_TRUNCATED,
        FLAW_LONE_CONT,
        FLAW_EDGE_CODE
    } t_flaw;

    logic i_clk;
    logic i_rst_n;

    utfv_in_if  in_if ();
    utfv_out_if out_if ();

    utf8_stream_validator u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if.sink),
        .o_out   (out_if.source)
    );

    t_in_item    byte_feed[$];
    logic        verdicts_due[$];
    logic [7:0]  str_bytes[$];

    // running decode state of the expected behaviour
    logic [1:0]        cont_left = 2'd0;
    logic [1:0]        seq_cont  = 2'd0;
    logic [CODE_W-1:0] code_acc  = '0;
    logic              str_bad   = 1'b0;

    logic        in_took  = 1'b0;
    logic        hold_off = 1'b0;
    int unsigned n_sent   = 0;
    int unsigned n_fail   = 0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic logic quiet_phase();
        return n_sent >= 700 && n_sent < 1000;
    endfunction

    // Advances the decode state by one item; returns 1 when the item closes a string.
    function automatic bit predict_verdict(input t_in_item it, output logic verdict);
        logic [7:0]        c;
        logic [CODE_W-1:0] code;
        c = it.data_byte;
        verdict = 1'b0;
        if (it.has_byte && !str_bad) begin
            if (cont_left == 2'd0) begin
                if (c == 8'h00) begin
                    str_bad = 1'b1;
                end else if (c >= C_ASCII_LIMIT) begin
                    if ((c & C_LEAD2_MASK) == C_LEAD2_VAL) begin
                        cont_left = 2'd1;
                        seq_cont  = 2'd1;
                        code_acc  = {{(CODE_W-8){1'b0}}, c & C_LEAD2_BITS};
                    end else if ((c & C_LEAD3_MASK) == C_LEAD3_VAL) begin
                        cont_left = 2'd2;
                        seq_cont  = 2'd2;
                        code_acc  = {{(CODE_W-8){1'b0}}, c & C_LEAD3_BITS};
                    end else if ((c & C_LEAD4_MASK) == C_LEAD4_VAL) begin
                        cont_left = 2'd3;
                        seq_cont  = 2'd3;
                        code_acc  = {{(CODE_W-8){1'b0}}, c & C_LEAD4_BITS};
                    end else begin
                        str_bad = 1'b1;
                    end
                end
            end else if ((c & C_CONT_MASK) != C_CONT_VAL) begin
                str_bad = 1'b1;
            end else begin
                // shift in six payload bits, top bits fall off the 21-bit code
                code      = {code_acc[CODE_W-7:0], c[5:0]};
                code_acc  = code;
                cont_left = cont_left - 2'd1;
                if (cont_left == 2'd0) begin
                    if ((seq_cont == 2'd1 && code < C_MIN_2BYTE) ||
                        (seq_cont == 2'd2 && code < C_MIN_3BYTE) ||
                        (seq_cont == 2'd3 && code < C_MIN_4BYTE) ||
                        code > C_MAX_CODE ||
                        (code >= C_SURR_LO && code <= C_SURR_HI)) begin
                        str_bad = 1'b1;
                    end
                    seq_cont = 2'd0;
                    code_acc = '0;
                end
            end
        end
        if (!it.end_of_string) begin
            return 1'b0;
        end
        verdict   = !str_bad && cont_left == 2'd0;
        cont_left = 2'd0;
        seq_cont  = 2'd0;
        code_acc  = '0;
        str_bad   = 1'b0;
        return 1'b1;
    endfunction

    function automatic void push_item(input logic [7:0] d, input logic has, input logic last);
        t_in_item it;
        it.data_byte     = d;
        it.has_byte      = has;
        it.end_of_string = last;
        byte_feed.insert(byte_feed.size(), it);
    endfunction

    function automatic void add_byte(input logic [7:0] b);
        str_bytes.insert(str_bytes.size(), b);
    endfunction

    // Encodes cp in nb bytes, whether or not that is the shortest form.
    function automatic void add_code(input logic [20:0] cp, input int nb);
        case (nb)
            1: add_byte({1'b0, cp[6:0]});
            2: begin
                add_byte({3'b110, cp[10:6]});
                add_byte({2'b10, cp[5:0]});
            end
            3: begin
                add_byte({4'b1110, cp[15:12]});
                add_byte({2'b10, cp[11:6]});
                add_byte({2'b10, cp[5:0]});
            end
            default: begin
                add_byte({5'b11110, cp[20:18]});
                add_byte({2'b10, cp[17:12]});
                add_byte({2'b10, cp[11:6]});
                add_byte({2'b10, cp[5:0]});
            end
        endcase
    endfunction

    function automatic void add_legal_char();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 40) begin
            add_code(21'($urandom_range(1, 'h7F)), 1);
        end else if (r < 65) begin
            add_code(21'($urandom_range('h80, 'h7FF)), 2);
        end else if (r < 85) begin
            if ($urandom_range(0, 1) == 0) begin
                add_code(21'($urandom_range('h800, 'hD7FF)), 3);
            end else begin
                add_code(21'($urandom_range('hE000, 'hFFFF)), 3);
            end
        end else begin
            add_code(21'($urandom_range('h10000, 'h10FFFF)), 4);
        end
    endfunction

    function automatic void add_flawed_char();
        int unsigned edges[12] = '{'h7F, 'h80, 'h7FF, 'h800, 'hD7FF, 'hD800,
                                   'hDFFF, 'hE000, 'hFFFF, 'h10000, 'h10FFFF, 'h110000};
        int unsigned cp;
        int          nb;
        t_flaw       flaw;
        flaw = t_flaw'($urandom_range(0, 7));
        case (flaw)
            FLAW_NUL:       add_byte(8'h00);
            FLAW_ANY_BYTE:  add_byte(8'($urandom_range(0, 255)));
            FLAW_OVERLONG: begin
                nb = $urandom_range(2, 4);
                cp = (nb == 2) ? $urandom_range(0, 'h7F) :
                     (nb == 3) ? $urandom_range(0, 'h7FF) : $urandom_range(0, 'hFFFF);
                add_code(21'(cp), nb);
            end
            FLAW_SURROGATE: add_code(21'($urandom_range('hD800, 'hDFFF)), 3);
            FLAW_TOO_HIGH:  add_code(21'($urandom_range('h110000, 'h1FFFFF)), 4);
            FLAW_TRUNCATED: begin
                nb = $urandom_range(2, 4);
                add_code(21'($urandom_range(0, 'h1FFFFF)), nb);
                repeat ($urandom_range(1, nb - 1)) void'(str_bytes.pop_back());
            end
            FLAW_LONE_CONT: add_byte(8'($urandom_range('h80, 'hBF)));
            default: begin
                cp = edges[$urandom_range(0, 11)];
                nb = (cp < 'h80) ? 1 : (cp < 'h800) ? 2 : (cp < 'h10000) ? 3 : 4;
                add_code(21'(cp), nb);
            end
        endcase
    endfunction

    // Turns the gathered bytes into items, with stray empty items and either
    // closing style.
    function automatic void close_string();
        int n;
        bit sep;
        n = str_bytes.size();
        if (n == 0) begin
            push_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        end else begin
            sep = ($urandom_range(0, 4) == 0);
            foreach (str_bytes[k]) begin
                if ($urandom_range(0, 99) < 4) begin
                    push_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
                end
                push_item(str_bytes[k], 1'b1, !sep && k == n - 1);
            end
            if (sep) begin
                push_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
            end
        end
        str_bytes.delete();
    endfunction

    function automatic void gen_string();
        int nchars;
        int flaw_at;
        nchars  = $urandom_range(0, 6);
        flaw_at = -1;
        if ($urandom_range(0, 99) < 8) begin
            repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(0, 255)));
        end else begin
            if (nchars > 0 && $urandom_range(0, 99) < 30) begin
                flaw_at = $urandom_range(0, nchars - 1);
            end
            for (int k = 0; k < nchars; k++) begin
                if (k == flaw_at) begin
                    add_flawed_char();
                end else begin
                    add_legal_char();
                end
            end
        end
        close_string();
    endfunction

    // Input transfers feed the prediction; output transfers are checked against it.
    always @(posedge i_clk) begin : sample_edge
        t_in_item it;
        logic     verdict;
        logic     expected;
        in_took <= i_rst_n && in_if.valid && in_if.ready;
        if (i_rst_n && in_if.valid && in_if.ready) begin
            it.data_byte     = in_if.data_byte;
            it.has_byte      = in_if.has_byte;
            it.end_of_string = in_if.end_of_string;
            n_sent++;
            if (predict_verdict(it, verdict)) begin
                verdicts_due.insert(verdicts_due.size(), verdict);
            end
        end
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (verdicts_due.size() == 0) begin
                $error("is_valid: no verdict expected, actual %0b", out_if.is_valid);
                n_fail++;
            end else begin
                expected = verdicts_due.pop_front();
                if (out_if.is_valid !== expected) begin
                    $error("is_valid mismatch: expected %0b, actual %0b",
                           expected, out_if.is_valid);
                    n_fail++;
                end
            end
        end
    end

    always @(negedge i_clk) begin : drive_edge
        t_in_item it;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (!in_if.valid || in_took) begin
            if (byte_feed.size() != 0 && (quiet_phase() || $urandom_range(0, 99) >= 11)) begin
                it = byte_feed.pop_front();
                in_if.valid         <= 1'b1;
                in_if.data_byte     <= it.data_byte;
                in_if.has_byte      <= it.has_byte;
                in_if.end_of_string <= it.end_of_string;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
        out_if.ready <= i_rst_n && !hold_off && (quiet_phase() || $urandom_range(0, 99) >= 11);
    end

    // Long receiver stall while the sender keeps going, so closing items back up.
    initial begin
        wait (n_sent >= 300);
        @(negedge i_clk);
        hold_off <= 1'b1;
        repeat (150) @(negedge i_clk);
        hold_off <= 1'b0;
    end

    initial begin
        i_rst_n             = 1'b0;
        in_if.valid         = 1'b0;
        in_if.data_byte     = 8'h00;
        in_if.has_byte      = 1'b0;
        in_if.end_of_string = 1'b0;
        out_if.ready        = 1'b0;

        push_item(8'hA5, 1'b0, 1'b1);                 // empty string
        push_item(8'h00, 1'b1, 1'b1);                 // NUL
        push_item(8'h7F, 1'b1, 1'b1);
        push_item(8'h80, 1'b1, 1'b1);                 // continuation as lead
        push_item(8'hF8, 1'b1, 1'b0);                 // bad lead, then ignored byte
        push_item(8'hFF, 1'b1, 1'b1);
        push_item(8'hC0, 1'b1, 1'b0);                 // overlong two-byte
        push_item(8'h80, 1'b1, 1'b1);
        push_item(8'hED, 1'b1, 1'b0);                 // surrogate
        push_item(8'hA0, 1'b1, 1'b0);
        push_item(8'h80, 1'b1, 1'b1);
        push_item(8'hF4, 1'b1, 1'b0);                 // above U+10FFFF
        push_item(8'h90, 1'b1, 1'b0);
        push_item(8'h80, 1'b1, 1'b0);
        push_item(8'h80, 1'b1, 1'b1);
        push_item(8'hC2, 1'b1, 1'b0);                 // missing continuation
        push_item(8'h41, 1'b1, 1'b1);
        push_item(8'hE2, 1'b1, 1'b0);                 // truncated, closed by an empty item
        push_item(8'h5A, 1'b0, 1'b0);
        push_item(8'h82, 1'b1, 1'b0);
        push_item(8'h00, 1'b0, 1'b1);
        push_item(8'hF4, 1'b1, 1'b0);                 // highest legal code point
        push_item(8'h8F, 1'b1, 1'b0);
        push_item(8'hBF, 1'b1, 1'b0);
        push_item(8'hBF, 1'b1, 1'b1);

        while (byte_feed.size() < 1425) gen_string();

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (byte_feed.size() != 0 || in_if.valid) @(posedge i_clk);
        while (verdicts_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (n_fail == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+design
design/utfv_pkg.sv
design/utfv_stream_if.sv
design/utfv_step.sv
design/utf8_stream_validator.sv
sim/utf8_stream_validator_test.sv
